@@ rtl/core/swv_pkg.sv @@
// ----------------------------------------------------------------------------
// swv_pkg
// shared types, widths and codes of the wall visibility block
// ----------------------------------------------------------------------------
package swv_pkg;

	localparam int MAX_WALLS = 64;
	localparam int ADDR_W    = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int CNT_W     = $clog2(MAX_WALLS + 1);

	localparam int COORD_W = 24;   // signed Q15.8
	localparam int HALF_W  = 23;   // unsigned Q15.8
	localparam int WIDX_W  = 6;    // wall_index / blocker_index field
	localparam int CFG_W   = 23;   // widest register
	localparam int COUNT_W = 7;
	localparam int DELTA_W = COORD_W + 1;
	localparam int REL_W   = COORD_W + 2;
	localparam int PROD_W  = 2 * REL_W;

	localparam logic [HALF_W-1:0] RADIUS_RESET = 23'd102400;

	typedef enum logic [0:0] {
		REG_SIGHT_RADIUS = 1'b0,
		REG_WALL_COUNT   = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		KIND_WRITE = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [HALF_W-1:0]         hw;
		logic [HALF_W-1:0]         hh;
	} wall_t;

	typedef struct packed {
		logic              visible;
		logic              out_of_range;
		logic              blocked;
		logic [WIDX_W-1:0] blocker_index;
		logic              write_done;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RNG_DX,
		ST_RNG_DY,
		ST_RNG_R,
		ST_RNG_CMP,
		ST_WALL_RD,
		ST_WALL_REL,
		ST_WALL_X,
		ST_Y_P0,
		ST_Y_P1,
		ST_Y_P2,
		ST_Y_P3,
		ST_Y_P4,
		ST_RESULT
	} state_t;

endpackage

@@ rtl/core/swv_if.sv @@
// ----------------------------------------------------------------------------
// swv_in_if / swv_out_if
// valid/ready channels for items and results
// ----------------------------------------------------------------------------
interface swv_in_if;
	import swv_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [WIDX_W-1:0]          wall_index;
	logic signed [COORD_W-1:0]  wall_x;
	logic signed [COORD_W-1:0]  wall_y;
	logic [HALF_W-1:0]          wall_half_width;
	logic [HALF_W-1:0]          wall_half_height;
	logic signed [COORD_W-1:0]  viewer_x;
	logic signed [COORD_W-1:0]  viewer_y;
	logic signed [COORD_W-1:0]  target_x;
	logic signed [COORD_W-1:0]  target_y;

	modport source (
		output valid, kind, wall_index, wall_x, wall_y, wall_half_width,
		       wall_half_height, viewer_x, viewer_y, target_x, target_y,
		input  ready
	);
	modport sink (
		input  valid, kind, wall_index, wall_x, wall_y, wall_half_width,
		       wall_half_height, viewer_x, viewer_y, target_x, target_y,
		output ready
	);
endinterface

interface swv_out_if;
	import swv_pkg::*;

	logic              valid;
	logic              ready;
	logic              visible;
	logic              out_of_range;
	logic              blocked;
	logic [WIDX_W-1:0] blocker_index;
	logic              write_done;

	modport source (
		output valid, visible, out_of_range, blocked, blocker_index, write_done,
		input  ready
	);
	modport sink (
		input  valid, visible, out_of_range, blocked, blocker_index, write_done,
		output ready
	);
endinterface

@@ rtl/core/segment_wall_visibility.sv @@
// ----------------------------------------------------------------------------
// segment_wall_visibility
// line-of-sight test of a viewer-to-target segment against a wall table
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          beat contents
//  item      in    valid/ready        wall write or visibility query
//  result    out   valid/ready        visible, out_of_range, blocked, index, done
//  cfg       in    cfg_we             register index and data, no back-pressure
//
//  a wall write goes from accept through the result state to the output register
//  a query runs the range check (dx, dy, radius products and the compare), then
//  per wall the registered table read, relative bounds and x slab; when the x slab
//  passes and the y delta is nonzero, the y products follow on the single shared
//  multiplier (4 cross products per such wall); out of range ends after the range check
//  arst_n clears the sequencer, output valid and the configuration registers to reset values
//  the next item is taken while a finished beat waits on result.ready
//
module segment_wall_visibility (
	input  logic                        clk,
	input  logic                        arst_n,
	swv_in_if.sink                      item,
	swv_out_if.source                   result,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [swv_pkg::CFG_W-1:0]   cfg_data
);
	import swv_pkg::*;

	state_t state_q, state_d;

	// configuration
	logic [HALF_W-1:0]  radius_q;
	logic [COUNT_W-1:0] count_q;

	// query operands
	logic signed [COORD_W-1:0] vx_q, vy_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;
	logic [DELTA_W-1:0]        adx_q, ady_q;    // |dx|, |dy|

	// scan state
	logic [CNT_W-1:0]          idx_q, lim_q;
	logic signed [PROD_W-1:0]  acc_q;           // dist2, then held cross product
	logic signed [REL_W-1:0]   nnx_q, fnx_q, nny_q, fny_q;
	logic [DELTA_W-1:0]        a_q, b_q, dxu_q; // x interval as a/dxu .. b/dxu
	logic                      c1_q;
	result_t                   res_q;
	logic                      out_valid_q;
	result_t                   out_q;

	logic accept;
	logic out_load;

	// shared multiplier
	logic signed [REL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_s1;

	// wall table
	logic           wall_we;
	wall_t          wall_wr, wall_rd;

	// relative bounds and x slab combinational terms
	logic signed [REL_W-1:0] cx26, cy26, hw26, hh26, vx26, vy26;
	logic signed [REL_W-1:0] lox, hix, loy, hiy;
	logic signed [REL_W-1:0] nnx_d, fnx_d, nny_d, fny_d;
	logic signed [REL_W-1:0] adx26, amax, bmin;
	logic                    x_zero, y_zero, x_pass, y_flat_pass;
	logic                    last_wall;

	assign accept      = item.valid && item.ready;
	assign item.ready  = (state_q == ST_IDLE);
	assign out_load    = (state_q == ST_RESULT) && (!out_valid_q || result.ready);

	assign wall_we = accept && (kind_t'(item.kind) == KIND_WRITE)
	                 && (32'(item.wall_index) < MAX_WALLS);
	assign wall_wr = '{cx: item.wall_x, cy: item.wall_y,
	                   hw: item.wall_half_width, hh: item.wall_half_height};

	swv_wall_store u_store (
		.clk     (clk),
		.we      (wall_we),
		.wr_addr (ADDR_W'(item.wall_index)),
		.wr_data (wall_wr),
		.rd_addr (idx_q[ADDR_W-1:0]),
		.rd_data (wall_rd)
	);

	swv_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (prod_s1)
	);

	// wall bounds relative to the viewer; a negative delta mirrors the slab
	assign cx26 = REL_W'(wall_rd.cx);
	assign cy26 = REL_W'(wall_rd.cy);
	assign hw26 = $signed(REL_W'(wall_rd.hw));
	assign hh26 = $signed(REL_W'(wall_rd.hh));
	assign vx26 = REL_W'(vx_q);
	assign vy26 = REL_W'(vy_q);
	assign lox  = cx26 - hw26;
	assign hix  = cx26 + hw26;
	assign loy  = cy26 - hh26;
	assign hiy  = cy26 + hh26;
	assign nnx_d = dx_q[DELTA_W-1] ? (vx26 - hix) : (lox - vx26);
	assign fnx_d = dx_q[DELTA_W-1] ? (vx26 - lox) : (hix - vx26);
	assign nny_d = dy_q[DELTA_W-1] ? (vy26 - hiy) : (loy - vy26);
	assign fny_d = dy_q[DELTA_W-1] ? (vy26 - loy) : (hiy - vy26);

	// x slab over the common denominator |dx|: [max(0,nn), min(|dx|,fn)]
	assign x_zero = (dx_q == '0);
	assign y_zero = (dy_q == '0);
	assign adx26  = $signed(REL_W'(adx_q));
	assign amax   = (!nnx_q[REL_W-1] && nnx_q != '0) ? nnx_q : '0;
	assign bmin   = (fnx_q < adx26) ? fnx_q : adx26;
	assign x_pass = x_zero ? ((nnx_q[REL_W-1] || nnx_q == '0) && !fnx_q[REL_W-1])
	                       : (amax <= bmin);
	assign y_flat_pass = (nny_q[REL_W-1] || nny_q == '0) && !fny_q[REL_W-1];

	assign last_wall = ((idx_q + CNT_W'(1)) == lim_q);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_RNG_DX: begin
				mul_a = REL_W'(dx_q);
				mul_b = REL_W'(dx_q);
			end
			ST_RNG_DY: begin
				mul_a = REL_W'(dy_q);
				mul_b = REL_W'(dy_q);
			end
			ST_RNG_R: begin
				mul_a = $signed(REL_W'(radius_q));
				mul_b = $signed(REL_W'(radius_q));
			end
			ST_Y_P0: begin
				mul_a = $signed(REL_W'(a_q));
				mul_b = $signed(REL_W'(ady_q));
			end
			ST_Y_P1: begin
				mul_a = fny_q;
				mul_b = $signed(REL_W'(dxu_q));
			end
			ST_Y_P2: begin
				mul_a = nny_q;
				mul_b = $signed(REL_W'(dxu_q));
			end
			ST_Y_P3: begin
				mul_a = $signed(REL_W'(b_q));
				mul_b = $signed(REL_W'(ady_q));
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (kind_t'(item.kind) == KIND_WRITE) ? ST_RESULT : ST_RNG_DX;
				end
			end
			ST_RNG_DX:  state_d = ST_RNG_DY;
			ST_RNG_DY:  state_d = ST_RNG_R;
			ST_RNG_R:   state_d = ST_RNG_CMP;
			ST_RNG_CMP: begin
				if (acc_q > prod_s1 || lim_q == '0) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_WALL_RD;
				end
			end
			ST_WALL_RD:  state_d = ST_WALL_REL;
			ST_WALL_REL: state_d = ST_WALL_X;
			ST_WALL_X: begin
				if (x_pass && !y_zero) begin
					state_d = ST_Y_P0;
				end else if ((x_pass && y_flat_pass) || last_wall) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_WALL_RD;
				end
			end
			ST_Y_P0: state_d = ST_Y_P1;
			ST_Y_P1: state_d = ST_Y_P2;
			ST_Y_P2: state_d = ST_Y_P3;
			ST_Y_P3: state_d = ST_Y_P4;
			ST_Y_P4: begin
				if ((c1_q && acc_q <= prod_s1) || last_wall) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_WALL_RD;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			count_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SIGHT_RADIUS: radius_q <= cfg_data[HALF_W-1:0];
				REG_WALL_COUNT:   count_q  <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_q <= '{visible: 1'b0, out_of_range: 1'b0, blocked: 1'b0,
					           blocker_index: '0,
					           write_done: (kind_t'(item.kind) == KIND_WRITE)};
					idx_q <= '0;
					vx_q <= item.viewer_x;
					vy_q <= item.viewer_y;
					dx_q <= DELTA_W'(item.target_x) - DELTA_W'(item.viewer_x);
					dy_q <= DELTA_W'(item.target_y) - DELTA_W'(item.viewer_y);
				end
			end
			ST_RNG_DX: begin
				adx_q <= dx_q[DELTA_W-1] ? DELTA_W'(-dx_q) : DELTA_W'(dx_q);
				ady_q <= dy_q[DELTA_W-1] ? DELTA_W'(-dy_q) : DELTA_W'(dy_q);
				lim_q <= (32'(count_q) > MAX_WALLS) ? CNT_W'(MAX_WALLS) : CNT_W'(count_q);
			end
			ST_RNG_DY: acc_q <= prod_s1;
			ST_RNG_R:  acc_q <= acc_q + prod_s1;
			ST_RNG_CMP: begin
				if (acc_q > prod_s1) begin
					res_q.out_of_range <= 1'b1;
				end else if (lim_q == '0) begin
					res_q.visible <= 1'b1;
				end
			end
			ST_WALL_REL: begin
				nnx_q <= nnx_d;
				fnx_q <= fnx_d;
				nny_q <= nny_d;
				fny_q <= fny_d;
			end
			ST_WALL_X: begin
				// zero delta keeps the unit interval
				a_q   <= x_zero ? '0 : amax[DELTA_W-1:0];
				b_q   <= x_zero ? DELTA_W'(1) : bmin[DELTA_W-1:0];
				dxu_q <= x_zero ? DELTA_W'(1) : adx_q;
				if (!(x_pass && !y_zero)) begin
					if (x_pass && y_flat_pass) begin
						res_q.blocked       <= 1'b1;
						res_q.blocker_index <= WIDX_W'(idx_q);
					end else if (last_wall) begin
						res_q.visible <= 1'b1;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
			end
			ST_Y_P1: acc_q <= prod_s1;                   // a * |dy|
			ST_Y_P2: c1_q  <= (acc_q <= prod_s1);        // t0 <= far_y
			ST_Y_P3: acc_q <= prod_s1;                   // near_y * dxu
			ST_Y_P4: begin
				if (c1_q && acc_q <= prod_s1) begin
					res_q.blocked       <= 1'b1;
					res_q.blocker_index <= WIDX_W'(idx_q);
				end else if (last_wall) begin
					res_q.visible <= 1'b1;
				end else begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.visible       = out_q.visible;
	assign result.out_of_range  = out_q.out_of_range;
	assign result.blocked       = out_q.blocked;
	assign result.blocker_index = out_q.blocker_index;
	assign result.write_done    = out_q.write_done;
endmodule

@@ rtl/core/swv_mul.sv @@
// ----------------------------------------------------------------------------
// swv_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module swv_mul (
	input  logic                                clk,
	input  logic signed [swv_pkg::REL_W-1:0]    a,
	input  logic signed [swv_pkg::REL_W-1:0]    b,
	output logic signed [swv_pkg::PROD_W-1:0]   p_s1
);
	import swv_pkg::*;

	always_ff @(posedge clk) begin
		p_s1 <= PROD_W'(a) * PROD_W'(b);
	end
endmodule

@@ rtl/core/swv_wall_store.sv @@
// ----------------------------------------------------------------------------
// swv_wall_store
// wall table, one write port and one registered read port
// ----------------------------------------------------------------------------
module swv_wall_store (
	input  logic                         clk,
	input  logic                         we,
	input  logic [swv_pkg::ADDR_W-1:0]   wr_addr,
	input  swv_pkg::wall_t               wr_data,
	input  logic [swv_pkg::ADDR_W-1:0]   rd_addr,
	output swv_pkg::wall_t               rd_data
);
	import swv_pkg::*;

	wall_t mem [MAX_WALLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule
